/* rtl/core/leb_pkg.sv */
// Shared types, constants and decode function for the line edit buffer.
// Used by every module under rtl/core but leb_ram; depends on nothing else.
`default_nettype none

package leb_pkg;

	// Buffer geometry.
	localparam int LINE_CAP = 64;
	localparam int ADDR_W   = $clog2(LINE_CAP);
	localparam int CNT_W    = $clog2(LINE_CAP + 1);

	// Fixed field widths of the command and result beats.
	localparam int OPC_W  = 2;
	localparam int KEY_W  = 8;
	localparam int CHAR_W = 16;
	localparam int REP_W  = 7;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;

	// Common width for compares that mix counts, indexes and repeat counts.
	localparam int CMP_A = (REP_W > IDX_W) ? REP_W : IDX_W;
	localparam int CMP_W = (CMP_A > CNT_W) ? CMP_A : CNT_W;

	// Two prompt characters precede the text on screen.
	localparam logic [LEN_W-1:0] PROMPT_COLS = LEN_W'(2);

	// Virtual key codes with a meaning of their own.
	localparam logic [KEY_W-1:0] KEY_BACK   = 8'h08;
	localparam logic [KEY_W-1:0] KEY_TAB    = 8'h09;
	localparam logic [KEY_W-1:0] KEY_RETURN = 8'h0D;
	localparam logic [KEY_W-1:0] KEY_ESCAPE = 8'h1B;
	localparam logic [KEY_W-1:0] KEY_END    = 8'h23;
	localparam logic [KEY_W-1:0] KEY_HOME   = 8'h24;
	localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h25;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h27;
	localparam logic [KEY_W-1:0] KEY_DELETE = 8'h2E;

	typedef enum logic [OPC_W-1:0] {
		OP_KEY   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_BACK,
		ACT_DEL,
		ACT_HOME,
		ACT_END,
		ACT_LEFT,
		ACT_RIGHT,
		ACT_INS
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_SHIFT_DN,
		ST_SHIFT_UP,
		ST_FILL
	} state_t;

	typedef enum logic [1:0] {
		PL_HOLD,
		PL_CURSOR,
		PL_CURSOR_P1,
		PL_FILL
	} ptr_load_t;

	// Final update of length and cursor; anything but UPD_NONE ends the item.
	typedef enum logic [3:0] {
		UPD_NONE,
		UPD_NOP,
		UPD_READ,
		UPD_CLEAR,
		UPD_HOME,
		UPD_END,
		UPD_LEFT,
		UPD_RIGHT,
		UPD_BACK,
		UPD_DEL,
		UPD_INS
	} upd_t;

	typedef struct packed {
		logic      latch;
		ptr_load_t ptr_load;
		logic      step_dn;
		logic      step_up;
		logic      fill_wr;
		logic      rd_req;
		logic      load_k;
		upd_t      upd;
	} dp_cmd_t;

	typedef struct packed {
		op_t  opc;
		act_t act;
		logic line_full;
		logic cur_zero;
		logic cur_at_end;
		logic ptr_lt_fill;
		logic ptr_gt_cur;
		logic ptr_lt_end;
	} dp_status_t;

	// Classifies a key event independent of the buffer state.
	function automatic act_t key_action(input logic down, input logic [KEY_W-1:0] code,
		input logic [CHAR_W-1:0] ch);
		act_t act;
		act = ACT_NONE;
		if (down) begin
			unique case (code) inside
				KEY_BACK: act = ACT_BACK;
				KEY_DELETE: act = ACT_DEL;
				KEY_HOME: act = ACT_HOME;
				KEY_END: act = ACT_END;
				KEY_LEFT: act = ACT_LEFT;
				KEY_RIGHT: act = ACT_RIGHT;
				KEY_TAB, KEY_RETURN, KEY_ESCAPE: act = ACT_NONE;
				default: act = (ch[7:0] != 8'h00) ? ACT_INS : ACT_NONE;
			endcase
		end
		return act;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/leb_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none

module leb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/leb_datapath.sv */
// Datapath of the line edit buffer: latched command, length, cursor, move pointer,
// character RAM and result registers. Depends on leb_pkg and leb_ram.
`default_nettype none

module leb_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [leb_pkg::OPC_W-1:0]        opcode,
	input  wire logic                             key_down,
	input  wire logic [leb_pkg::KEY_W-1:0]        key_code,
	input  wire logic [leb_pkg::CHAR_W-1:0]       char_value,
	input  wire logic [leb_pkg::REP_W-1:0]        repeat_count,
	input  wire logic [leb_pkg::IDX_W-1:0]        read_index,
	input  wire leb_pkg::dp_cmd_t                 cmd,
	output leb_pkg::dp_status_t                   status,
	output logic                                  done,
	output logic                                  changed,
	output logic [leb_pkg::LEN_W-1:0]             line_length,
	output logic [leb_pkg::LEN_W-1:0]             cursor_pos,
	output logic [leb_pkg::LEN_W-1:0]             cursor_column,
	output logic [leb_pkg::CHAR_W-1:0]            read_char,
	output logic                                  read_valid
);

	// Latched command beat.
	leb_pkg::op_t                 opc_q;
	logic                         down_q;
	logic [leb_pkg::KEY_W-1:0]    code_q;
	logic [leb_pkg::CHAR_W-1:0]   ch_q;
	logic [leb_pkg::REP_W-1:0]    reps_q;
	logic [leb_pkg::IDX_W-1:0]    idx_q;

	// Buffer state and move control.
	logic [leb_pkg::CNT_W-1:0]    fill_q;
	logic [leb_pkg::CNT_W-1:0]    cursor_q;
	logic [leb_pkg::CNT_W-1:0]    ptr_q;
	logic [leb_pkg::CNT_W-1:0]    k_q;
	logic                         valid_s1;
	logic [leb_pkg::ADDR_W-1:0]   dest_s1;

	// Result registers.
	logic                         done_q;
	logic                         changed_q;
	logic [leb_pkg::CHAR_W-1:0]   read_char_q;
	logic                         read_valid_q;

	// Derived values.
	logic [leb_pkg::CNT_W-1:0]    ptr_dec;
	logic [leb_pkg::CNT_W-1:0]    up_dest;
	logic [leb_pkg::CNT_W-1:0]    ins_end;
	logic [leb_pkg::CNT_W-1:0]    room;
	logic [leb_pkg::CNT_W-1:0]    k_next;
	logic                         idx_in_line;

	// RAM ports.
	logic                         ram_we;
	logic [leb_pkg::ADDR_W-1:0]   ram_waddr;
	logic [leb_pkg::CHAR_W-1:0]   ram_wdata;
	logic [leb_pkg::ADDR_W-1:0]   ram_raddr;
	logic [leb_pkg::CHAR_W-1:0]   ram_rdata;

	// Address arithmetic for the move beats, insertion count clamp and read index check.
	always_comb begin
		ptr_dec = ptr_q - leb_pkg::CNT_W'(1);
		up_dest = ptr_dec + k_q;
		ins_end = cursor_q + k_q;
		room    = leb_pkg::CNT_W'(leb_pkg::LINE_CAP) - fill_q;
		if (leb_pkg::CMP_W'(reps_q) < leb_pkg::CMP_W'(room)) begin
			k_next = leb_pkg::CNT_W'(reps_q);
		end else begin
			k_next = room;
		end
		idx_in_line = leb_pkg::CMP_W'(idx_q) < leb_pkg::CMP_W'(fill_q);
	end

	// Status toward the controller.
	always_comb begin
		status.opc         = opc_q;
		status.act         = leb_pkg::key_action(down_q, code_q, ch_q);
		status.line_full   = fill_q == leb_pkg::CNT_W'(leb_pkg::LINE_CAP);
		status.cur_zero    = cursor_q == '0;
		status.cur_at_end  = cursor_q == fill_q;
		status.ptr_lt_fill = ptr_q < fill_q;
		status.ptr_gt_cur  = ptr_q > cursor_q;
		status.ptr_lt_end  = ptr_q < ins_end;
	end

	// RAM port selection: a pending move write, or a fill write of the new character.
	always_comb begin
		ram_we    = valid_s1 | cmd.fill_wr;
		ram_waddr = valid_s1 ? dest_s1 : ptr_q[leb_pkg::ADDR_W-1:0];
		ram_wdata = valid_s1 ? ram_rdata : ch_q;
		if (cmd.rd_req) begin
			ram_raddr = idx_q[leb_pkg::ADDR_W-1:0];
		end else if (cmd.step_up) begin
			ram_raddr = ptr_dec[leb_pkg::ADDR_W-1:0];
		end else begin
			ram_raddr = ptr_q[leb_pkg::ADDR_W-1:0];
		end
	end

	leb_ram #(
		.WIDTH(leb_pkg::CHAR_W),
		.DEPTH(leb_pkg::LINE_CAP)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Command beat, pointer, insertion count, move stage payload and read character.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			opc_q  <= leb_pkg::op_t'(opcode);
			down_q <= key_down;
			code_q <= key_code;
			ch_q   <= char_value;
			reps_q <= repeat_count;
			idx_q  <= read_index;
		end
		if (cmd.load_k) begin
			k_q <= k_next;
		end
		unique case (cmd.ptr_load)
			leb_pkg::PL_CURSOR: ptr_q <= cursor_q;
			leb_pkg::PL_CURSOR_P1: ptr_q <= cursor_q + leb_pkg::CNT_W'(1);
			leb_pkg::PL_FILL: ptr_q <= fill_q;
			default: begin
				if (cmd.step_dn || cmd.fill_wr) begin
					ptr_q <= ptr_q + leb_pkg::CNT_W'(1);
				end else if (cmd.step_up) begin
					ptr_q <= ptr_dec;
				end
			end
		endcase
		if (cmd.step_dn) begin
			dest_s1 <= ptr_dec[leb_pkg::ADDR_W-1:0];
		end else begin
			dest_s1 <= up_dest[leb_pkg::ADDR_W-1:0];
		end
		if (cmd.upd == leb_pkg::UPD_READ) begin
			read_char_q <= idx_in_line ? ram_rdata : '0;
		end else if (cmd.upd != leb_pkg::UPD_NONE) begin
			read_char_q <= '0;
		end
	end

	// Length, cursor, move stage valid, result strobe and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			cursor_q     <= '0;
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			changed_q    <= 1'b0;
			read_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.step_dn | cmd.step_up;
			done_q   <= cmd.upd != leb_pkg::UPD_NONE;
			if (cmd.upd != leb_pkg::UPD_NONE) begin
				changed_q    <= !(cmd.upd == leb_pkg::UPD_NOP || cmd.upd == leb_pkg::UPD_READ);
				read_valid_q <= (cmd.upd == leb_pkg::UPD_READ) && idx_in_line;
			end
			unique case (cmd.upd)
				leb_pkg::UPD_CLEAR: begin
					fill_q   <= '0;
					cursor_q <= '0;
				end
				leb_pkg::UPD_HOME: cursor_q <= '0;
				leb_pkg::UPD_END: cursor_q <= fill_q;
				leb_pkg::UPD_LEFT: cursor_q <= cursor_q - leb_pkg::CNT_W'(1);
				leb_pkg::UPD_RIGHT: cursor_q <= cursor_q + leb_pkg::CNT_W'(1);
				leb_pkg::UPD_BACK: begin
					fill_q   <= fill_q - leb_pkg::CNT_W'(1);
					cursor_q <= cursor_q - leb_pkg::CNT_W'(1);
				end
				leb_pkg::UPD_DEL: fill_q <= fill_q - leb_pkg::CNT_W'(1);
				leb_pkg::UPD_INS: begin
					fill_q   <= fill_q + k_q;
					cursor_q <= ins_end;
				end
				default: begin
				end
			endcase
		end
	end

	// Result ports.
	always_comb begin
		done          = done_q;
		changed       = changed_q;
		line_length   = leb_pkg::LEN_W'(fill_q);
		cursor_pos    = leb_pkg::LEN_W'(cursor_q);
		cursor_column = leb_pkg::LEN_W'(cursor_q) + leb_pkg::PROMPT_COLS;
		read_char     = read_char_q;
		read_valid    = read_valid_q;
	end

endmodule

`default_nettype wire

/* rtl/core/leb_ctrl.sv */
// Controller state machine of the line edit buffer: decodes each command beat
// and sequences the character moves. Depends on leb_pkg.
`default_nettype none

module leb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire leb_pkg::dp_status_t status,
	output leb_pkg::dp_cmd_t         cmd,
	output logic                     busy
);

	leb_pkg::state_t state_q;
	leb_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= leb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd.latch    = 1'b0;
		cmd.ptr_load = leb_pkg::PL_HOLD;
		cmd.step_dn  = 1'b0;
		cmd.step_up  = 1'b0;
		cmd.fill_wr  = 1'b0;
		cmd.rd_req   = 1'b0;
		cmd.load_k   = 1'b0;
		cmd.upd      = leb_pkg::UPD_NONE;
		busy         = state_q != leb_pkg::ST_IDLE;

		unique case (state_q)
			leb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = leb_pkg::ST_DECODE;
				end
			end
			leb_pkg::ST_DECODE: begin
				state_d = leb_pkg::ST_IDLE;
				unique case (status.opc)
					leb_pkg::OP_CLEAR: cmd.upd = leb_pkg::UPD_CLEAR;
					leb_pkg::OP_READ: begin
						cmd.rd_req = 1'b1;
						state_d    = leb_pkg::ST_READ;
					end
					leb_pkg::OP_NOP: cmd.upd = leb_pkg::UPD_NOP;
					default: begin
						unique case (status.act)
							leb_pkg::ACT_HOME: cmd.upd = leb_pkg::UPD_HOME;
							leb_pkg::ACT_END: cmd.upd = leb_pkg::UPD_END;
							leb_pkg::ACT_LEFT: begin
								cmd.upd = status.cur_zero ? leb_pkg::UPD_NOP : leb_pkg::UPD_LEFT;
							end
							leb_pkg::ACT_RIGHT: begin
								cmd.upd = status.cur_at_end ? leb_pkg::UPD_NOP
									: leb_pkg::UPD_RIGHT;
							end
							leb_pkg::ACT_BACK: begin
								if (status.cur_zero) begin
									cmd.upd = leb_pkg::UPD_NOP;
								end else begin
									cmd.ptr_load = leb_pkg::PL_CURSOR;
									state_d      = leb_pkg::ST_SHIFT_DN;
								end
							end
							leb_pkg::ACT_DEL: begin
								if (status.cur_at_end) begin
									cmd.upd = leb_pkg::UPD_NOP;
								end else begin
									cmd.ptr_load = leb_pkg::PL_CURSOR_P1;
									state_d      = leb_pkg::ST_SHIFT_DN;
								end
							end
							leb_pkg::ACT_INS: begin
								if (status.line_full) begin
									cmd.upd = leb_pkg::UPD_NOP;
								end else begin
									cmd.load_k   = 1'b1;
									cmd.ptr_load = leb_pkg::PL_FILL;
									state_d      = leb_pkg::ST_SHIFT_UP;
								end
							end
							default: cmd.upd = leb_pkg::UPD_NOP;
						endcase
					end
				endcase
			end
			leb_pkg::ST_READ: begin
				cmd.upd = leb_pkg::UPD_READ;
				state_d = leb_pkg::ST_IDLE;
			end
			// Close the gap: move each character after the removed one down by one.
			leb_pkg::ST_SHIFT_DN: begin
				if (status.ptr_lt_fill) begin
					cmd.step_dn = 1'b1;
				end else begin
					cmd.upd = (status.act == leb_pkg::ACT_BACK) ? leb_pkg::UPD_BACK
						: leb_pkg::UPD_DEL;
					state_d = leb_pkg::ST_IDLE;
				end
			end
			// Open a gap at the cursor, moving the tail up from its last character.
			leb_pkg::ST_SHIFT_UP: begin
				if (status.ptr_gt_cur) begin
					cmd.step_up = 1'b1;
				end else begin
					state_d = leb_pkg::ST_FILL;
				end
			end
			// Write the inserted copies into the gap.
			leb_pkg::ST_FILL: begin
				if (status.ptr_lt_end) begin
					cmd.fill_wr = 1'b1;
				end else begin
					cmd.upd = leb_pkg::UPD_INS;
					state_d = leb_pkg::ST_IDLE;
				end
			end
			default: state_d = leb_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/line_edit_buffer.sv */
// Top level of the line edit buffer: joins the controller and the datapath.
// Depends on leb_pkg, leb_ctrl, leb_datapath and leb_ram.
`default_nettype none

// A command beat is taken on a clock edge with start high and busy low, and
// each beat gives exactly one result beat, marked by done for a single cycle;
// the receiver cannot stall it, so it must sample the result in that cycle.
// The next command may be presented in the cycle that done is high. Clear,
// cursor moves, ignored keys and no-ops give their result from the decode
// state, a read from the read state after it. Backspace and delete then move
// each character behind the removed one down, and an insertion of k copies
// moves each character behind the cursor up and then writes the k copies.
// These moves go through the single character RAM, which moves one
// character per cycle through its one read and one write port. The RAM
// needs no clearing after reset; only data from positions below the line
// length is ever used.
module line_edit_buffer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [leb_pkg::OPC_W-1:0]  opcode,
	input  wire logic                       key_down,
	input  wire logic [leb_pkg::KEY_W-1:0]  key_code,
	input  wire logic [leb_pkg::CHAR_W-1:0] char_value,
	input  wire logic [leb_pkg::REP_W-1:0]  repeat_count,
	input  wire logic [leb_pkg::IDX_W-1:0]  read_index,
	output logic                            done,
	output logic                            changed,
	output logic [leb_pkg::LEN_W-1:0]       line_length,
	output logic [leb_pkg::LEN_W-1:0]       cursor_pos,
	output logic [leb_pkg::LEN_W-1:0]       cursor_column,
	output logic [leb_pkg::CHAR_W-1:0]      read_char,
	output logic                            read_valid
);

	leb_pkg::dp_cmd_t    cmd;
	leb_pkg::dp_status_t status;

	leb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	leb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.key_down     (key_down),
		.key_code     (key_code),
		.char_value   (char_value),
		.repeat_count (repeat_count),
		.read_index   (read_index),
		.cmd          (cmd),
		.status       (status),
		.done         (done),
		.changed      (changed),
		.line_length  (line_length),
		.cursor_pos   (cursor_pos),
		.cursor_column(cursor_column),
		.read_char    (read_char),
		.read_valid   (read_valid)
	);

`ifndef ASSERT_OFF
	// The cursor never passes the end of the line in a result beat.
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> cursor_pos <= line_length)
		else $error("cursor beyond line end");

	// The line never grows past its capacity.
	a_length_cap: assert property (@(posedge clk) disable iff (!arst_n)
		line_length <= leb_pkg::LEN_W'(leb_pkg::LINE_CAP))
		else $error("line length above capacity");

	// A taken command keeps the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command taken without going busy");

	// A result beat only appears once the item has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");
`endif

endmodule

`default_nettype wire
